// ===== hw/rtl/atrt_pkg.sv =====
// shared types for the arrival time ring tracker
// slot entry layout, opcodes and controller states; no dependencies
package atrt_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } atrt_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_PUT,
        ST_CLR,
        ST_WALK,
        ST_RESP
    } atrt_state_t;

    // one ring slot as stored in memory
    typedef struct packed {
        logic        valid;
        logic [31:0] ts;
        logic [63:0] arrival;
    } atrt_entry_t;

endpackage

// ===== hw/rtl/atrt_ram.sv =====
// slot memory of the arrival time ring tracker
// one write port, one read port with registered data; uses atrt_pkg
module atrt_ram
    import atrt_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  atrt_entry_t      wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output atrt_entry_t      rdata
);

    atrt_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/atrt_slot_map.sv =====
// sequence offset to ring slot: offset mod DEPTH in three pipeline stages
// reciprocal multiply, quotient times depth, subtract with one correction
module atrt_slot_map #(
    parameter int DEPTH = 128,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [15:0]      diff,
    output logic             done,
    output logic [IDX_W-1:0] slot
);

    localparam longint unsigned RECIP_L =
        ((64'd1 << 32) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [31:0] RECIP   = 32'(RECIP_L);
    localparam logic [16:0] DEPTH_W = 17'(DEPTH);

    logic [2:0]       stg_reg;
    logic [47:0]      prod_reg;
    logic [15:0]      diff1_reg;
    logic [15:0]      diff2_reg;
    logic [31:0]      qd_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [16:0]      rem;
    logic [16:0]      rem_fix;

    always_comb begin
        rem = {1'b0, diff2_reg} - qd_reg[16:0];
        if (rem >= DEPTH_W) begin
            rem_fix = rem - DEPTH_W;
        end else begin
            rem_fix = rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_reg <= '0;
        end else begin
            stg_reg <= {stg_reg[1:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= 48'(diff) * 48'(RECIP);
        diff1_reg <= diff;
        qd_reg    <= 32'(prod_reg[47:32]) * 32'(DEPTH);
        diff2_reg <= diff1_reg;
        slot_reg  <= rem_fix[IDX_W-1:0];
    end

    assign done = stg_reg[2];
    assign slot = slot_reg;

endmodule

// ===== hw/rtl/arrival_time_ring_tracker.sv =====
// arrival time ring tracker; an insert maps its sequence offset to a slot and writes it,
// a lookup visits slots one at a time through the single read port of the slot memory,
// a clear sweeps every slot; an overrunning insert adds a clearing sweep of every slot
// one item at a time: the next transfer is taken once the result is registered,
// even while that result still waits in the output register
// reset (aresetn low, synchronous) runs a memory sweep over every slot with s_tready held low
module arrival_time_ring_tracker
    import atrt_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // packet_seq[15:0], media_timestamp[47:16],
                                    // arrival_time_in[111:48]
    input  logic [1:0]   s_tuser,   // opcode[1:0]
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // arrival_time_out[63:0]
    output logic         m_tuser    // found[0]
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // input transfer fields
    logic [15:0]        s_seq;
    logic [31:0]        s_ts;
    logic [63:0]        s_arr;
    atrt_op_t           s_op;

    assign s_seq = s_tdata[15:0];
    assign s_ts  = s_tdata[47:16];
    assign s_arr = s_tdata[111:48];
    assign s_op  = atrt_op_t'(s_tuser);

    // control state
    atrt_state_t        state_reg, state_next;
    logic               init_reg, init_next;
    logic [IDX_W-1:0]   read_pos_reg, read_pos_next;
    logic [IDX_W-1:0]   last_wr_reg, last_wr_next;
    logic [15:0]        base_reg, base_next;
    logic               base_known_reg, base_known_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               fwd_kill_reg, fwd_kill_next;
    logic               out_valid_reg, out_valid_next;

    // payload state
    atrt_op_t           op_reg, op_next;
    logic [15:0]        seq_reg, seq_next;
    logic [31:0]        qts_reg, qts_next;
    logic [63:0]        arr_reg, arr_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic               tail_reg, tail_next;
    logic               first_reg, first_next;
    logic [IDX_W-1:0]   put_slot_reg, put_slot_next;
    logic               res_found_reg, res_found_next;
    logic [63:0]        res_arr_reg, res_arr_next;
    logic               out_found_reg, out_found_next;
    logic [63:0]        out_arr_reg, out_arr_next;

    // memory and slot map hookup
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    atrt_entry_t        mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    atrt_entry_t        mem_rdata;
    logic               map_start;
    logic [15:0]        map_diff;
    logic               map_done;
    logic [IDX_W-1:0]   map_slot;

    // walk decode of the slot that just came out of memory
    logic               ent_valid;
    logic               consume;
    logic               stop;
    logic [IDX_W-1:0]   prev_idx;

    atrt_ram #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    atrt_slot_map #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_slot_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (map_start),
        .diff    (map_diff),
        .done    (map_done),
        .slot    (map_slot)
    );

    // a slot written in the same cycle as its read comes back stale: treat as empty
    assign ent_valid = mem_rdata.valid && !fwd_kill_reg;
    assign consume   = ent_valid && (mem_rdata.ts <= qts_reg);
    assign stop      = ent_valid && !consume;
    assign prev_idx  = (cur_reg == '0) ? LAST_IDX : cur_reg - 1'b1;

    // offset from the base; the first insert anchors the base at its own number
    assign map_diff  = s_seq - (base_known_reg ? base_reg : s_seq);

    always_comb begin
        state_next      = state_reg;
        init_next       = init_reg;
        read_pos_next   = read_pos_reg;
        last_wr_next    = last_wr_reg;
        base_next       = base_reg;
        base_known_next = base_known_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        seq_next        = seq_reg;
        qts_next        = qts_reg;
        arr_next        = arr_reg;
        cur_next        = cur_reg;
        tail_next       = tail_reg;
        first_next      = first_reg;
        put_slot_next   = put_slot_reg;
        res_found_next  = res_found_reg;
        res_arr_next    = res_arr_reg;
        out_found_next  = out_found_reg;
        out_arr_next    = out_arr_reg;

        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = cur_reg;
        map_start = 1'b0;

        s_tready  = (state_reg == ST_IDLE);

        // result register drains independently of the controller
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next        = s_op;
                    seq_next       = s_seq;
                    qts_next       = s_ts;
                    arr_next       = s_arr;
                    res_found_next = 1'b0;
                    res_arr_next   = '0;
                    case (s_op)
                        OP_INSERT: begin
                            if (!base_known_reg) begin
                                base_next       = s_seq;
                                base_known_next = 1'b1;
                            end
                            map_start  = 1'b1;
                            state_next = ST_SLOT;
                        end
                        OP_LOOKUP: begin
                            // first visit is always the slot at the read position
                            mem_re     = 1'b1;
                            mem_raddr  = read_pos_reg;
                            cur_next   = read_pos_reg;
                            tail_next  = (read_pos_reg > last_wr_reg);
                            first_next = 1'b1;
                            state_next = ST_WALK;
                        end
                        OP_CLEAR: begin
                            read_pos_next = '0;
                            last_wr_next  = '0;
                            clr_cnt_next  = '0;
                            state_next    = ST_CLR;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SLOT: begin
                if (map_done) begin
                    if ((read_pos_reg > last_wr_reg) && (read_pos_reg < map_slot)) begin
                        // overrun: empty the ring, re-anchor, packet lands in slot zero
                        read_pos_next = '0;
                        last_wr_next  = '0;
                        base_next     = seq_reg;
                        put_slot_next = '0;
                        clr_cnt_next  = '0;
                        state_next    = ST_CLR;
                    end else begin
                        put_slot_next = map_slot;
                        state_next    = ST_PUT;
                    end
                end
            end

            ST_PUT: begin
                mem_we       = 1'b1;
                mem_waddr    = put_slot_reg;
                mem_wdata    = '{valid: 1'b1, ts: qts_reg, arrival: arr_reg};
                last_wr_next = put_slot_reg;
                state_next   = ST_RESP;
            end

            ST_CLR: begin
                // clearing sweep, one slot per cycle
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX) begin
                    if (init_reg) begin
                        init_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else if (op_reg == OP_INSERT) begin
                        state_next = ST_PUT;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_WALK: begin
                first_next = 1'b0;
                if (consume) begin
                    // take this entry, drop the one behind it
                    mem_we         = 1'b1;
                    mem_waddr      = prev_idx;
                    mem_wdata      = '0;
                    read_pos_next  = cur_reg;
                    res_found_next = 1'b1;
                    res_arr_next   = mem_rdata.arrival;
                end else if (first_reg) begin
                    res_found_next = ent_valid;
                    res_arr_next   = ent_valid ? mem_rdata.arrival : '0;
                end

                if (tail_reg) begin
                    // tail segment; the head segment always follows
                    mem_re = 1'b1;
                    if (stop || (cur_reg == LAST_IDX)) begin
                        mem_raddr = '0;
                        cur_next  = '0;
                        tail_next = 1'b0;
                    end else begin
                        mem_raddr = cur_reg + 1'b1;
                        cur_next  = cur_reg + 1'b1;
                    end
                end else begin
                    if (stop || (cur_reg == last_wr_reg)) begin
                        state_next = ST_RESP;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = cur_reg + 1'b1;
                        cur_next  = cur_reg + 1'b1;
                    end
                end
            end

            ST_RESP: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_arr_next   = res_arr_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        fwd_kill_next = mem_we && mem_re && (mem_waddr == mem_raddr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLR;
            init_reg       <= 1'b1;
            read_pos_reg   <= '0;
            last_wr_reg    <= '0;
            base_reg       <= '0;
            base_known_reg <= 1'b0;
            clr_cnt_reg    <= '0;
            fwd_kill_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            read_pos_reg   <= read_pos_next;
            last_wr_reg    <= last_wr_next;
            base_reg       <= base_next;
            base_known_reg <= base_known_next;
            clr_cnt_reg    <= clr_cnt_next;
            fwd_kill_reg   <= fwd_kill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        seq_reg       <= seq_next;
        qts_reg       <= qts_next;
        arr_reg       <= arr_next;
        cur_reg       <= cur_next;
        tail_reg      <= tail_next;
        first_reg     <= first_next;
        put_slot_reg  <= put_slot_next;
        res_found_reg <= res_found_next;
        res_arr_reg   <= res_arr_next;
        out_found_reg <= out_found_next;
        out_arr_reg   <= out_arr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_arr_reg;
    assign m_tuser  = out_found_reg;

endmodule

// ===== test/arrival_time_ring_tracker_tb.sv =====
// self-checking testbench for the arrival time ring tracker
// drives directed and random insert/lookup/clear transfers with random idling and checks every
// result against a behavioral ring predictor or a typed table answer; depends on atrt_pkg and the block
module arrival_time_ring_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import atrt_pkg::*;

    localparam int RING_SLOTS   = 128;
    localparam int RANDOM_ITEMS = 1125;
    localparam int MAX_GAP      = 6;

    // one answer of the block: found flag and arrival time
    typedef struct packed {
        logic        found;
        logic [63:0] arrival;
    } lookup_answer_t;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        atrt_op_t       op;
        logic [15:0]    seq;
        logic [31:0]    ts;
        logic [63:0]    arrival;
        logic           typed;
        lookup_answer_t want;
    } ring_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;   // packet_seq[15:0], media_timestamp[47:16],
                             // arrival_time_in[111:48]
    logic [1:0]   s_tuser;   // opcode[1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // arrival_time_out[63:0]
    logic         m_tuser;   // found[0]

    arrival_time_ring_tracker #(
        .DEPTH(RING_SLOTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // predictor copy of the ring
    bit             ring_valid [RING_SLOTS];
    logic [31:0]    ring_ts    [RING_SLOTS];
    logic [63:0]    ring_time  [RING_SLOTS];
    int unsigned    ring_rd;
    int unsigned    ring_wr;
    logic [15:0]    base_seq = '0;
    bit             base_set = 1'b0;

    lookup_answer_t pending_answers[$];
    ring_row_t      directed_rows[$];
    int             mismatch_count = 0;
    int             results_seen   = 0;
    int             results_paced  = 0;
    int             ready_hold     = 0;
    bit             steady_flow    = 1'b0;   // both sides run without idling

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // generous cap, several times the slowest legal run
    initial begin
        #6_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH %0s", $realtime, msg);
    endtask

    function automatic void ring_empty();
        foreach (ring_valid[i]) ring_valid[i] = 1'b0;
        ring_rd = 0;
        ring_wr = 0;
    endfunction

    // consume entries first..last whose timestamp does not exceed the query
    function automatic void ring_walk(input int unsigned first, input int unsigned last,
                                      input logic [31:0] query);
        for (int unsigned i = first; i <= last && i < RING_SLOTS; i++) begin
            if (!ring_valid[i]) continue;
            if (ring_ts[i] <= query) begin
                ring_valid[(i == 0) ? RING_SLOTS - 1 : i - 1] = 1'b0;
                ring_rd = i;
            end else begin
                break;
            end
        end
    endfunction

    // advance the predicted ring by one transfer and give its answer
    function automatic lookup_answer_t ring_apply(input atrt_op_t op, input logic [15:0] seq,
                                                  input logic [31:0] ts,
                                                  input logic [63:0] arrival);
        lookup_answer_t ans;
        logic [15:0]    seq_delta;
        int unsigned    slot;
        int unsigned    start;
        ans = '0;
        case (op)
            OP_INSERT: begin
                if (!base_set) begin
                    base_seq = seq;
                    base_set = 1'b1;
                end
                seq_delta = seq - base_seq;
                slot = seq_delta % RING_SLOTS;
                // read position stranded between last write and new slot: overrun
                if (ring_rd > ring_wr && ring_rd < slot) begin
                    ring_empty();
                    slot = 0;
                    base_seq = seq;
                end
                ring_valid[slot] = 1'b1;
                ring_ts[slot]    = ts;
                ring_time[slot]  = arrival;
                ring_wr          = slot;
            end
            OP_LOOKUP: begin
                start = ring_rd;
                // wrapped ring: tail first, then always the head
                if (ring_rd > ring_wr) begin
                    ring_walk(ring_rd, RING_SLOTS - 1, ts);
                    start = 0;
                end
                ring_walk(start, ring_wr, ts);
                if (ring_valid[ring_rd]) begin
                    ans.found   = 1'b1;
                    ans.arrival = ring_time[ring_rd];
                end
            end
            OP_CLEAR: begin
                ring_empty();
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // one input transfer after a random gap; queues the expected answer on acceptance
    task automatic drive_item(input atrt_op_t op, input logic [15:0] seq,
                              input logic [31:0] ts, input logic [63:0] arrival,
                              input logic typed, input lookup_answer_t want);
        int             gap;
        lookup_answer_t ans;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {arrival, ts, seq};
        do @(posedge aclk); while (!s_tready);
        ans = ring_apply(op, seq, ts, arrival);
        pending_answers.push_back(typed ? want : ans);
    endtask

    // hold the sender off until every queued answer has come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    // result side: check every transfer against the oldest expectation
    always @(posedge aclk) begin : result_check
        lookup_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result with none outstanding: found=%0b arrival=%h",
                                          m_tuser, m_tdata));
            end else begin
                want = pending_answers.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch($sformatf("found: got %0b want %0b", m_tuser, want.found));
                if (m_tdata !== want.arrival)
                    report_mismatch($sformatf("arrival: got %h want %h", m_tdata, want.arrival));
            end
        end
    end

    // result side backpressure: a fresh stall after each transfer
    always @(negedge aclk) begin
        if (results_seen != results_paced) begin
            results_paced = results_seen;
            ready_hold    = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        int             burst;
        int             pick;
        int             sent;
        atrt_op_t       op;
        logic [15:0]    seq;
        logic [31:0]    ts;
        logic [63:0]    arrival;
        logic [15:0]    stream_seq;
        logic [31:0]    stream_ts;
        logic [63:0]    stream_arr;
        bit             noisy;
        lookup_answer_t none;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_NOP;
        none     = '0;
        ring_empty();

        // directed table: after the first insert the base is 0xffff
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'hFFFF_FFFF, 64'h0, 1'b1,
                                  '{1'b0, 64'h0}});   // empty ring answers nothing
        directed_rows.push_back('{OP_NOP, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                  1'b1, '{1'b0, 64'h0}});
        directed_rows.push_back('{OP_CLEAR, 16'h0000, 32'h0, 64'h0, 1'b1, '{1'b0, 64'h0}});
        directed_rows.push_back('{OP_INSERT, 16'hFFFF, 32'h0, 64'h8000_0000_0000_0000, 1'b1,
                                  '{1'b0, 64'h0}});   // anchors the base
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'h0, 64'h0, 1'b1,
                                  '{1'b1, 64'h8000_0000_0000_0000}});   // slot 0 clears last slot
        directed_rows.push_back('{OP_INSERT, 16'h0000, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                                  1'b1, '{1'b0, 64'h0}});   // sequence wraps to slot 1
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'hFFFF_FFFE, 64'h0, 1'b0, none});
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'hFFFF_FFFF, 64'h0, 1'b0, none});
        directed_rows.push_back('{OP_CLEAR, 16'h1234, 32'h5, 64'h9, 1'b1, '{1'b0, 64'h0}});
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'h0, 64'h0, 1'b0, none});
        directed_rows.push_back('{OP_INSERT, 16'h0004, 32'd100, 64'd5, 1'b0, none});
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'd100, 64'h0, 1'b0, none});
        // write behind the read position, then a query below both timestamps stops in both segments
        directed_rows.push_back('{OP_INSERT, 16'h0001, 32'd50, 64'd6, 1'b0, none});
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'd40, 64'h0, 1'b0, none});
        // lands past the read position: overrun, ring restarts at slot 0
        directed_rows.push_back('{OP_INSERT, 16'h0008, 32'd5, 64'd7, 1'b1, '{1'b0, 64'h0}});
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'hFFFF_FFFF, 64'h0, 1'b0, none});
        directed_rows.push_back('{OP_INSERT, 16'h0080, 32'd10, 64'd8, 1'b0, none});
        directed_rows.push_back('{OP_INSERT, 16'h0081, 32'd20, 64'd9, 1'b0, none});
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'd20, 64'h0, 1'b0, none});
        // wraps to slot 3, then a walk across the tail and the head
        directed_rows.push_back('{OP_INSERT, 16'h008B, 32'd30, 64'd10, 1'b0, none});
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'd30, 64'h0, 1'b0, none});
        directed_rows.push_back('{OP_INSERT, 16'h0087, 32'd40, 64'd11, 1'b0, none});
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'd35, 64'h0, 1'b0, none});
        directed_rows.push_back('{OP_LOOKUP, 16'h0000, 32'd0, 64'h0, 1'b0, none});
        directed_rows.push_back('{OP_NOP, 16'h5A5A, 32'hA5A5_A5A5, 64'h1, 1'b1,
                                  '{1'b0, 64'h0}});

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            drive_item(directed_rows[i].op, directed_rows[i].seq, directed_rows[i].ts,
                       directed_rows[i].arrival, directed_rows[i].typed,
                       directed_rows[i].want);
        drain_results();

        // random part: mostly ordered packet streams with lookups trailing them,
        // mixed with bursts of unconstrained transfers
        stream_seq = $urandom_range(0, 65535);
        stream_ts  = $urandom;
        stream_arr = {$urandom, $urandom};
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst       = $urandom_range(8, 40);
            steady_flow = ($urandom_range(0, 4) == 0);
            noisy       = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                seq     = $urandom_range(0, 65535);
                ts      = $urandom;
                arrival = {$urandom, $urandom};
                if (noisy) begin
                    op = atrt_op_t'($urandom_range(0, 3));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60) begin
                        op   = OP_INSERT;
                        pick = $urandom_range(0, 99);
                        if (pick < 75) begin
                            stream_seq = stream_seq + 16'd1;
                            seq = stream_seq;
                        end else if (pick < 85) begin
                            stream_seq = stream_seq + 16'($urandom_range(2, 4));
                            seq = stream_seq;
                        end else if (pick < 93) begin
                            // late packet, slightly out of order
                            seq = stream_seq - 16'($urandom_range(1, 3));
                        end else if (pick < 98) begin
                            // jump ahead, may overrun the read position
                            stream_seq = stream_seq + 16'($urandom_range(20, 140));
                            seq = stream_seq;
                        end
                        stream_ts  = stream_ts + $urandom_range(0, 2000);
                        stream_arr = stream_arr + 64'($urandom_range(1, 40000));
                        ts = stream_ts;
                        if ($urandom_range(0, 9) != 0) arrival = stream_arr;
                    end else if (pick < 93) begin
                        op   = OP_LOOKUP;
                        pick = $urandom_range(0, 99);
                        if (pick < 70)
                            ts = stream_ts - $urandom_range(0, 6000);
                        else if (pick < 85)
                            ts = stream_ts + $urandom_range(0, 3000);
                        else if (pick < 92)
                            ts = 32'hFFFF_FFFF;
                        else
                            ts = 32'h0;
                    end else if (pick < 96) begin
                        op = OP_CLEAR;
                    end else begin
                        op = OP_NOP;
                    end
                end
                drive_item(op, seq, ts, arrival, 1'b0, none);
                sent++;
            end
            if ($urandom_range(0, 6) == 0) drain_results();
        end

        steady_flow = 1'b0;
        drain_results();
        // any lookup walk or overrun sweep still running has finished by now
        repeat (2 * RING_SLOTS + 16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== arrival_time_ring_tracker.f =====
hw/rtl/atrt_pkg.sv
hw/rtl/atrt_ram.sv
hw/rtl/atrt_slot_map.sv
hw/rtl/arrival_time_ring_tracker.sv
test/arrival_time_ring_tracker_tb.sv
